/* hdl/rcct_pkg.sv */
// ---------------------------------------------------------------------------
// rcct_pkg: shared definitions for the row/column coverage tracker
// Board geometry, command codes, controller states and the command/status
// structures that pass between the controller and the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcct_pkg;

	// Board geometry
	localparam int BOARD_SIZE = 256;
	localparam int IDX_W      = $clog2(BOARD_SIZE);
	localparam int COORD_W    = 8;
	localparam int CNT_W      = 9;
	localparam int CMD_W      = 2;

	localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

	// Command codes carried on the command port
	localparam logic [CMD_W-1:0] CMD_PLACE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;

	// Controller states
	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic inc;
		logic dec;
		logic query;
	} dp_ctrl_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic [CMD_W-1:0] op;
	} dp_status_t;

endpackage

`default_nettype wire

/* hdl/rcct_count_bank.sv */
// ---------------------------------------------------------------------------
// rcct_count_bank: per-line item counts with occupancy bits
// Holds one count per row (or column) in a memory and one occupancy flag per
// line in flip-flops. The flag also marks the stored count as live, so a
// line whose flag is clear reads as a zero count and reset needs no sweep.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcct_count_bank (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               rd_en,
	input  wire logic [rcct_pkg::COORD_W-1:0]       rd_idx,
	input  wire logic                               inc,
	input  wire logic                               dec,
	output logic      [rcct_pkg::BOARD_SIZE-1:0]    occ
);

	logic [rcct_pkg::CNT_W-1:0]      mem [rcct_pkg::BOARD_SIZE];
	logic [rcct_pkg::CNT_W-1:0]      rd_data_q;
	logic [rcct_pkg::IDX_W-1:0]      idx_q;
	logic                            on_board_q;
	logic [rcct_pkg::BOARD_SIZE-1:0] occ_q;
	logic [rcct_pkg::CNT_W-1:0]      cur_cnt;
	logic [rcct_pkg::CNT_W-1:0]      new_cnt;
	logic                            wr_en;

	// Hold the line index and whether it lies on the board
	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_q      <= rcct_pkg::IDX_W'(rd_idx);
			on_board_q <= (32'(rd_idx) < rcct_pkg::BOARD_SIZE);
		end
	end

	// Saturating increment or floored decrement of the live count
	always_comb begin
		cur_cnt = occ_q[idx_q] ? rd_data_q : '0;
		if (inc) begin
			new_cnt = (cur_cnt == rcct_pkg::COUNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
		end else begin
			new_cnt = (cur_cnt == '0) ? cur_cnt : cur_cnt - 1'b1;
		end
		wr_en = (inc | dec) & on_board_q;
	end

	// Count memory: registered read at capture, write back on update
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rcct_pkg::IDX_W'(rd_idx)];
		end
		if (wr_en) begin
			mem[idx_q] <= new_cnt;
		end
	end

	// Occupancy flags follow the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (wr_en) begin
			occ_q[idx_q] <= (new_cnt != '0);
		end
	end

	assign occ = occ_q;

	// An update never lands on the same cycle as a new read
	a_no_rd_during_update: assert property (@(posedge clk) disable iff (!arst_n)
		(inc || dec) |-> !rd_en)
		else $error("count bank read while updating");

	// A flag only changes on a write to the bank
	a_occ_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(wr_en) |-> $stable(occ_q))
		else $error("occupancy changed without a write");

	// Increment and decrement are never requested together
	a_inc_dec_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(inc && dec))
		else $error("increment and decrement together");

endmodule

`default_nettype wire

/* hdl/rcct_datapath.sv */
// ---------------------------------------------------------------------------
// rcct_datapath: operand registers, count banks and range check
// Captures the command beat, drives the row and column count banks and
// tests a query range against the occupancy flags with a parallel mask.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcct_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rcct_pkg::dp_ctrl_t             ctl,
	output rcct_pkg::dp_status_t                sts,
	input  wire logic [rcct_pkg::CMD_W-1:0]     command,
	input  wire logic [rcct_pkg::COORD_W-1:0]   row_a,
	input  wire logic [rcct_pkg::COORD_W-1:0]   col_a,
	input  wire logic [rcct_pkg::COORD_W-1:0]   row_b,
	input  wire logic [rcct_pkg::COORD_W-1:0]   col_b,
	output logic                                done,
	output logic                                covered,
	output logic                                rows_full,
	output logic                                cols_full
);

	logic [rcct_pkg::CMD_W-1:0]      op_s1;
	logic [rcct_pkg::COORD_W-1:0]    row_lo_s1;
	logic [rcct_pkg::COORD_W-1:0]    row_hi_s1;
	logic [rcct_pkg::COORD_W-1:0]    col_lo_s1;
	logic [rcct_pkg::COORD_W-1:0]    col_hi_s1;
	logic [rcct_pkg::BOARD_SIZE-1:0] row_occ;
	logic [rcct_pkg::BOARD_SIZE-1:0] col_occ;
	logic                            row_ok;
	logic                            col_ok;
	logic                            done_q;
	logic                            covered_q;
	logic                            rows_full_q;
	logic                            cols_full_q;

	// Hold the command beat
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			op_s1     <= command;
			row_lo_s1 <= row_a;
			col_lo_s1 <= col_a;
			row_hi_s1 <= row_b;
			col_hi_s1 <= col_b;
		end
	end

	assign sts.op = op_s1;

	// Row and column count banks
	rcct_count_bank u_row_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (ctl.capture),
		.rd_idx (row_a),
		.inc    (ctl.inc),
		.dec    (ctl.dec),
		.occ    (row_occ)
	);

	rcct_count_bank u_col_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.rd_en  (ctl.capture),
		.rd_idx (col_a),
		.inc    (ctl.inc),
		.dec    (ctl.dec),
		.occ    (col_occ)
	);

	// Mask the flags with the range; lines off the board count as empty
	always_comb begin
		row_ok = (row_lo_s1 <= row_hi_s1) && (32'(row_hi_s1) < rcct_pkg::BOARD_SIZE);
		col_ok = (col_lo_s1 <= col_hi_s1) && (32'(col_hi_s1) < rcct_pkg::BOARD_SIZE);
		for (int i = 0; i < rcct_pkg::BOARD_SIZE; i++) begin
			if ((i >= 32'(row_lo_s1)) && (i <= 32'(row_hi_s1)) && !row_occ[i]) begin
				row_ok = 1'b0;
			end
			if ((i >= 32'(col_lo_s1)) && (i <= 32'(col_hi_s1)) && !col_occ[i]) begin
				col_ok = 1'b0;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.query;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (ctl.query) begin
			covered_q   <= row_ok | col_ok;
			rows_full_q <= row_ok;
			cols_full_q <= col_ok;
		end
	end

	assign done      = done_q;
	assign covered   = covered_q;
	assign rows_full = rows_full_q;
	assign cols_full = cols_full_q;

	// A result beat only follows a query
	a_done_after_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(ctl.query))
		else $error("result without a query");

	// A full row range was never reversed
	a_rows_not_reversed: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rows_full) |-> $past(row_lo_s1 <= row_hi_s1))
		else $error("full row range reported for a reversed range");

	// Covered is the OR of the two flags
	a_covered_or: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (covered == (rows_full || cols_full)))
		else $error("covered disagrees with range flags");

endmodule

`default_nettype wire

/* hdl/rcct_ctrl.sv */
// ---------------------------------------------------------------------------
// rcct_ctrl: command sequencer for the coverage tracker
// Takes a command beat when idle, then issues the count update or the
// range query to the datapath from its execute state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcct_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	output rcct_pkg::dp_ctrl_t         ctl,
	input  wire rcct_pkg::dp_status_t  sts
);

	rcct_pkg::state_t state_q;
	rcct_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcct_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			rcct_pkg::ST_IDLE: begin
				if (start) begin
					state_nxt = rcct_pkg::ST_EXEC;
				end
			end
			rcct_pkg::ST_EXEC: begin
				state_nxt = rcct_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = rcct_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs
	always_comb begin
		busy        = 1'b0;
		ctl.capture = 1'b0;
		ctl.inc     = 1'b0;
		ctl.dec     = 1'b0;
		ctl.query   = 1'b0;
		case (state_q)
			rcct_pkg::ST_IDLE: begin
				ctl.capture = start;
			end
			rcct_pkg::ST_EXEC: begin
				busy      = 1'b1;
				ctl.inc   = (sts.op == rcct_pkg::CMD_PLACE);
				ctl.dec   = (sts.op == rcct_pkg::CMD_REMOVE);
				ctl.query = (sts.op == rcct_pkg::CMD_QUERY);
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// Each accepted beat moves the sequencer into the execute state
	a_exec_after_capture: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.capture |=> (state_q == rcct_pkg::ST_EXEC))
		else $error("no execute cycle after capture");

	// At most one datapath operation per cycle
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.capture, ctl.inc, ctl.dec, ctl.query}))
		else $error("overlapping datapath operations");

	// Execute always hands back to idle on the next clock
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rcct_pkg::ST_EXEC) |=> (state_q == rcct_pkg::ST_IDLE))
		else $error("execute state held");

endmodule

`default_nettype wire

/* hdl/row_column_coverage_tracker.sv */
// ---------------------------------------------------------------------------
// row_column_coverage_tracker: row and column occupancy counter
// Counts placed items per row and per column of a square board and answers
// range coverage queries from the per-line occupancy flags.
//
//   Channel   Handshake             Fields
//   --------  --------------------  ----------------------------------------
//   command   start / busy          command, row_a, col_a, row_b, col_b
//   result    done (one-cycle beat) covered, rows_full, cols_full
//
// Each beat is handled in the accept cycle, which reads both count
// memories, and then in the execute cycle, which writes the updated counts
// back or evaluates the query mask. busy is high for the execute cycle only.
// A query result is presented for one cycle, the cycle after execute; the
// receiver cannot stall it. Place and remove give no result beat.
// Reset clears the occupancy flags at once; the count memories need no sweep
// since a line whose flag is clear reads as a zero count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module row_column_coverage_tracker (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           start,
	output logic                                busy,
	input  wire logic [rcct_pkg::CMD_W-1:0]     command,
	input  wire logic [rcct_pkg::COORD_W-1:0]   row_a,
	input  wire logic [rcct_pkg::COORD_W-1:0]   col_a,
	input  wire logic [rcct_pkg::COORD_W-1:0]   row_b,
	input  wire logic [rcct_pkg::COORD_W-1:0]   col_b,
	output logic                                done,
	output logic                                covered,
	output logic                                rows_full,
	output logic                                cols_full
);

	rcct_pkg::dp_ctrl_t   ctl;
	rcct_pkg::dp_status_t sts;

	// Sequencer
	rcct_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctl    (ctl),
		.sts    (sts)
	);

	// Counts, flags and range check
	rcct_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.sts       (sts),
		.command   (command),
		.row_a     (row_a),
		.col_a     (col_a),
		.row_b     (row_b),
		.col_b     (col_b),
		.done      (done),
		.covered   (covered),
		.rows_full (rows_full),
		.cols_full (cols_full)
	);

endmodule

`default_nettype wire
